[rtl/lir_pkg.sv]
// Shared types, constants and codes of the linear interpolation resampler.
`default_nettype none

package lir_pkg;

  // Defaults for the top level parameters.
  localparam int SAMPLE_WIDTH_DEF = 24;
  localparam int OUT_RATE_DEF     = 48000;
  localparam int FRAC_BITS_DEF    = 16;

  // Phase and rate widths are fixed by the register and state widths.
  localparam int PHASE_W = 18;
  localparam int ACC_W   = PHASE_W + 1;
  localparam int RATE_W  = 18;
  localparam int CHAN_W  = 4;

  localparam logic [RATE_W-1:0] RATE_MIN   = RATE_W'(8000);
  localparam logic [RATE_W-1:0] RATE_MAX   = RATE_W'(192000);
  localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(48000);

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = RATE_W;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_INPUT_RATE    = 1'b0,
    REG_CHANNEL_COUNT = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INTERP,
    ST_TAIL
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic               load;   // capture the accepted item's samples
    logic               mono;   // duplicate the first channel
    logic               issue;  // start one output down the pipeline
    logic               tail;   // output is a copy of the current frame
    logic               eos;    // output closes the stream
    logic [PHASE_W-1:0] phase;  // position of the output, below the output rate
  } ctl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic advance;  // the pipeline moves on this cycle
  } dp_status_t;

endpackage

`default_nettype wire

[rtl/lir_sample_if.sv]
// Input channel carrying one frame of two samples and the last frame mark.
`default_nettype none

interface lir_sample_if #(
  parameter int W = 24
);
  logic         valid;
  logic         ready;
  logic [W-1:0] sample_first;
  logic [W-1:0] sample_second;
  logic         last_frame;

  modport source (output valid, output sample_first, output sample_second,
                  output last_frame, input ready);
  modport sink (input valid, input sample_first, input sample_second,
                input last_frame, output ready);
endinterface

`default_nettype wire

[rtl/lir_frame_if.sv]
// Output channel carrying one stereo frame and the end of stream mark.
`default_nettype none

interface lir_frame_if #(
  parameter int W = 24
);
  logic         valid;
  logic         ready;
  logic [W-1:0] out_left;
  logic [W-1:0] out_right;
  logic         end_of_stream;

  modport source (output valid, output out_left, output out_right,
                  output end_of_stream, input ready);
  modport sink (input valid, input out_left, input out_right,
                input end_of_stream, output ready);
endinterface

`default_nettype wire

[rtl/lir_controller.sv]
// Controller: configuration registers, phase accumulator and sequencing FSM.
`default_nettype none

module lir_controller import lir_pkg::*; #(
  parameter int OUT_RATE = OUT_RATE_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  input  logic                   in_last,
  output logic                   in_ready,
  input  dp_status_t             status,
  output ctl_cmd_t               cmd
);

  localparam logic [ACC_W-1:0] OUT_ACC = ACC_W'(OUT_RATE);

  state_t             state, state_next;
  logic [ACC_W-1:0]   phase, phase_next;
  logic               have_prev, have_prev_next;
  logic               last_item, last_item_next;
  logic [RATE_W-1:0]  rate;
  logic               mono;
  logic               below;
  logic [ACC_W-1:0]   stepped;

  // The rate is saturated when it is written, so the loop sees it ready to use.
  always_ff @(posedge clk) begin
    if (rst) begin
      rate <= RATE_RESET;
      mono <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_INPUT_RATE: begin
          if (cfg_data[RATE_W-1:0] < RATE_MIN) begin
            rate <= RATE_MIN;
          end else if (cfg_data[RATE_W-1:0] > RATE_MAX) begin
            rate <= RATE_MAX;
          end else begin
            rate <= cfg_data[RATE_W-1:0];
          end
        end
        REG_CHANNEL_COUNT: mono <= (cfg_data[CHAN_W-1:0] <= CHAN_W'(1));
        default: mono <= mono;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      phase     <= '0;
      have_prev <= 1'b0;
      last_item <= 1'b0;
    end else begin
      state     <= state_next;
      phase     <= phase_next;
      have_prev <= have_prev_next;
      last_item <= last_item_next;
    end
  end

  assign below   = phase < OUT_ACC;
  assign stepped = phase + ACC_W'(rate);

  always_comb begin
    state_next     = state;
    phase_next     = phase;
    have_prev_next = have_prev;
    last_item_next = last_item;
    in_ready       = 1'b0;
    cmd            = '0;
    cmd.mono       = mono;
    cmd.tail       = (state == ST_TAIL);
    cmd.phase      = phase[PHASE_W-1:0];
    cmd.eos        = (state == ST_TAIL) && (stepped >= OUT_ACC);
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load       = 1'b1;
          last_item_next = in_last;
          if (have_prev) begin
            state_next = ST_INTERP;
          end else if (in_last) begin
            state_next = ST_TAIL;
          end else begin
            have_prev_next = 1'b1;
          end
        end
      end
      ST_INTERP: begin
        if (below) begin
          if (status.advance) begin
            cmd.issue  = 1'b1;
            phase_next = stepped;
          end
        end else begin
          phase_next = phase - OUT_ACC;
          state_next = last_item ? ST_TAIL : ST_IDLE;
        end
      end
      ST_TAIL: begin
        if (below) begin
          if (status.advance) begin
            cmd.issue  = 1'b1;
            phase_next = stepped;
          end
        end else begin
          phase_next     = '0;
          have_prev_next = 1'b0;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

[rtl/lir_datapath.sv]
// Datapath: sample registers, weight pipeline, interpolation and output register.
`default_nettype none

module lir_datapath import lir_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int OUT_RATE     = OUT_RATE_DEF,
  parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  ctl_cmd_t                cmd,
  output dp_status_t              status,
  input  logic [SAMPLE_WIDTH-1:0] sample_first,
  input  logic [SAMPLE_WIDTH-1:0] sample_second,
  lir_frame_if.source             frames
);

  localparam int DW = SAMPLE_WIDTH + 1;
  localparam int PW = SAMPLE_WIDTH + FRAC_BITS + 2;
  // Reciprocal of the output rate; the product is exact to within one unit.
  localparam logic [63:0] RECIP = (64'd1 << (FRAC_BITS + PHASE_W)) / OUT_RATE;
  localparam int MW     = $clog2(RECIP + 64'd1);
  localparam int PROD_W = PHASE_W + MW;
  localparam int REM_W  = PHASE_W + FRAC_BITS;
  localparam logic [MW-1:0]    RECIP_M = RECIP[MW-1:0];
  localparam logic [REM_W-1:0] OUT_REM = REM_W'(OUT_RATE);

  logic                           advance;
  logic signed [SAMPLE_WIDTH-1:0] prev_a, prev_b, cur_a, cur_b;

  logic v1, v2, v3, v4, out_valid;

  logic [PROD_W-1:0]              rm1;
  logic [PHASE_W-1:0]             r1, r2;
  logic [FRAC_BITS-1:0]           q2, w3;
  logic [REM_W-1:0]               qo2, rem;
  logic                           eos1, eos2, eos3, eos4, out_eos;
  logic signed [SAMPLE_WIDTH-1:0] bl1, br1, bl2, br2, bl3, br3, bl4, br4;
  logic signed [DW-1:0]           dl1, dr1, dl2, dr2, dl3, dr3;
  logic signed [PW-1:0]           pl4, pr4;
  logic [SAMPLE_WIDTH-1:0]        out_l, out_r;

  assign advance        = !out_valid || frames.ready;
  assign status.advance = advance;

  // Accepting a frame moves the current frame into the previous slot.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      prev_a <= cur_a;
      prev_b <= cur_b;
      cur_a  <= sample_first;
      cur_b  <= cmd.mono ? sample_first : sample_second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      v1        <= cmd.issue;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      out_valid <= v4;
    end
  end

  assign rem = {r2, {FRAC_BITS{1'b0}}} - qo2;

  always_ff @(posedge clk) begin
    if (advance) begin
      // Stage 1: phase times reciprocal, endpoints of the segment.
      rm1  <= PROD_W'(cmd.phase) * PROD_W'(RECIP_M);
      r1   <= cmd.phase;
      eos1 <= cmd.eos;
      if (cmd.tail) begin
        bl1 <= cur_a;
        br1 <= cur_b;
        dl1 <= '0;
        dr1 <= '0;
      end else begin
        bl1 <= prev_a;
        br1 <= prev_b;
        dl1 <= DW'(cur_a) - DW'(prev_a);
        dr1 <= DW'(cur_b) - DW'(prev_b);
      end
      // Stage 2: trial quotient back times the rate.
      q2   <= rm1[PHASE_W +: FRAC_BITS];
      qo2  <= REM_W'(rm1[PHASE_W +: FRAC_BITS]) * OUT_REM;
      r2   <= r1;
      eos2 <= eos1;
      bl2  <= bl1;
      br2  <= br1;
      dl2  <= dl1;
      dr2  <= dr1;
      // Stage 3: one correction step gives the exact floor.
      w3   <= (rem >= OUT_REM) ? q2 + FRAC_BITS'(1) : q2;
      eos3 <= eos2;
      bl3  <= bl2;
      br3  <= br2;
      dl3  <= dl2;
      dr3  <= dr2;
      // Stage 4: difference times weight.
      pl4  <= PW'(dl3) * PW'($signed({1'b0, w3}));
      pr4  <= PW'(dr3) * PW'($signed({1'b0, w3}));
      eos4 <= eos3;
      bl4  <= bl3;
      br4  <= br3;
      // Output register: base plus the floor-shifted product, wrapped.
      out_l   <= bl4 + pl4[FRAC_BITS +: SAMPLE_WIDTH];
      out_r   <= br4 + pr4[FRAC_BITS +: SAMPLE_WIDTH];
      out_eos <= eos4;
    end
  end

  assign frames.valid         = out_valid;
  assign frames.out_left      = out_l;
  assign frames.out_right     = out_r;
  assign frames.end_of_stream = out_eos;

endmodule

`default_nettype wire

[rtl/linear_interp_resampler_unit.sv]
// Top level of the linear interpolation sample rate converter.
//
//   Channel   Direction  Carries                                   Handshake
//   samples   in         sample_first, sample_second, last_frame  valid/ready
//   frames    out        out_left, out_right, end_of_stream        valid/ready
//   cfg       in         cfg_index, cfg_data                       cfg_we only
//
// An item is accepted in ST_IDLE; the first frame of a stream is only loaded there.
// A later frame moves to ST_INTERP, which issues outputs while the phase is below the output
// rate and then wraps the phase; a last frame then issues its tail copies in ST_TAIL.
// Each output reaches the frames channel through the weight pipeline and output register.
// Reset is synchronous and restores 48 kHz stereo and an empty stream state.
// An output item that is not taken freezes the pipeline and the issue; nothing is lost.
`default_nettype none

module linear_interp_resampler_unit import lir_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int OUT_RATE     = OUT_RATE_DEF,
  parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  lir_sample_if.sink             samples,
  lir_frame_if.source            frames
);

  ctl_cmd_t   cmd;
  dp_status_t status;
  logic       in_ready;

  // The controller owns the handshake of the input channel and the phase.
  lir_controller #(
    .OUT_RATE (OUT_RATE)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (samples.valid),
    .in_last   (samples.last_frame),
    .in_ready  (in_ready),
    .status    (status),
    .cmd       (cmd)
  );

  assign samples.ready = in_ready;

  // The datapath holds the samples and produces every output item.
  lir_datapath #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .OUT_RATE     (OUT_RATE),
    .FRAC_BITS    (FRAC_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .sample_first  (samples.sample_first),
    .sample_second (samples.sample_second),
    .frames        (frames)
  );

`ifndef NO_ASSERTIONS
  // An output is only started when the pipeline moves, or it would be lost.
  a_issue_on_advance: assert property (@(posedge clk) disable iff (rst)
    cmd.issue |-> status.advance)
    else $error("output issued while the pipeline is stalled");

  // Samples are never replaced while outputs of the held frame are issued.
  a_no_load_while_issuing: assert property (@(posedge clk) disable iff (rst)
    (samples.valid && samples.ready) |-> !cmd.issue)
    else $error("input item accepted during output issue");

  // A held output that is not taken must freeze the pipeline.
  a_stall_holds_pipeline: assert property (@(posedge clk) disable iff (rst)
    (frames.valid && !frames.ready) |-> !status.advance)
    else $error("pipeline advanced over a waiting output item");
`endif

endmodule

`default_nettype wire
